>>> src/rrte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrte_pkg;

  localparam int unsigned TypeW   = 8;
  localparam int unsigned HandleW = 8;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned RepW    = 8;
  localparam int unsigned TriesW  = 5;   // holds up to 31 attempts
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TimeW-1:0] AnswerTimeoutRst = 16'd200;
  localparam logic [TimeW-1:0] CooldownRst      = 16'd400;

  localparam logic [CfgIdxW-1:0] CFG_ANSWER_TIMEOUT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN       = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_ENQ   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_ENQ   = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    EV_SEND     = 3'd0,
    EV_INCOMING = 3'd1,
    EV_ANSWER   = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_REJECT   = 3'd4
  } event_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [TypeW-1:0]     msg_type;
    logic                 crc;
    logic                 one_shot;
    logic [TriesW-1:0]    tries;
    logic [TimeW-1:0]     gap;
    logic [HandleW-1:0]   handle;
  } cmd_t;

  typedef struct packed {
    logic [HandleW-1:0]   handle;
    logic [TypeW-1:0]     msg_type;
    logic                 crc;
    logic                 one_shot;
    logic [TriesW-1:0]    tries;
    logic [TimeW-1:0]     gap;
  } req_t;

  typedef struct packed {
    event_kind_e          kind;
    logic [TypeW-1:0]     event_type;
    logic [TypeW-1:0]     request_type;
    logic                 crc;
    logic [HandleW-1:0]   handle;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

>>> src/rrte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  msg_type;
  logic        crc_flag;
  logic        expects_no_answer;
  logic [7:0]  repeat_count;
  logic [15:0] retry_gap_ms;
  logic [7:0]  message_handle;

  modport source (output valid, opcode, msg_type, crc_flag, expects_no_answer,
                  repeat_count, retry_gap_ms, message_handle, input ready);
  modport sink (input valid, opcode, msg_type, crc_flag, expects_no_answer,
                repeat_count, retry_gap_ms, message_handle, output ready);
endinterface

interface rrte_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  event_type;
  logic [7:0]  request_type;
  logic        event_crc;
  logic [7:0]  event_handle;
  logic        last_of_run;

  modport source (output valid, event_kind, event_type, request_type, event_crc,
                  event_handle, last_of_run, input ready);
  modport sink (input valid, event_kind, event_type, request_type, event_crc,
                event_handle, last_of_run, output ready);
endinterface

interface rrte_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/request_retry_timeout_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Beat carries
// --------+-----+--------------------------------------------------------------
// req_i   | in  | opcode, msg_type, crc_flag, expects_no_answer, repeat_count,
//         |     | retry_gap_ms, message_handle
// cfg_i   | in  | index (0 answer timeout, 1 cooldown), data (16 bits)
// evt_o   | out | event_kind, event_type, request_type, event_crc, event_handle,
//         |     | last_of_run
//
// Steps: on the execution side each item passes through a fetch state, which
// reads the request queue head from its registered memory port, and an execute
// state, which updates state. The item after one that yields results waits in
// the execute step until the result slots have drained, and no new item is
// taken from the command queue until the execute step is done.
// Reset: rst_ni clears all control state; timeouts load 200 ms and 400 ms.
// Stalls: a two-beat command queue between intake and execution lets req_i take
// beats until it is full while a result waits on evt_o. cfg_i never stalls.
module request_retry_timeout_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_RETRIES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrte_in_if.sink     req_i,
  rrte_cfg_if.sink    cfg_i,
  rrte_out_if.source  evt_o
);
  import rrte_pkg::*;

  logic [TimeW-1:0] answer_timeout_q;
  logic [TimeW-1:0] cooldown_q;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  // Writes are registered; the user writes only with the engine idle, unchecked.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_timeout_q <= AnswerTimeoutRst;
      cooldown_q       <= CooldownRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ANSWER_TIMEOUT: answer_timeout_q <= cfg_i.data;
        CFG_COOLDOWN:       cooldown_q       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Intake: classify each beat, cap the attempt count, buffer commands.
  rrte_front #(
    .MAX_RETRIES (MAX_RETRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // Execution: timers, request queue, send / answer / timeout decisions.
  rrte_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .answer_timeout_i (answer_timeout_q),
    .cooldown_i       (cooldown_q),
    .evt              (evt_o)
  );

endmodule

`default_nettype wire

>>> src/rrte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rrte_front #(
  parameter int unsigned MAX_RETRIES = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrte_in_if.sink       req,
  output rrte_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import rrte_pkg::*;

  localparam logic [RepW-1:0]   RepCap   = RepW'(MAX_RETRIES);
  localparam logic [TriesW-1:0] TriesMax = TriesW'(MAX_RETRIES + 1);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_d;
  logic       push, pop;

  assign req.ready   = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Classify the beat; the unused opcode is taken and dropped here.
  always_comb begin
    cmd_d            = '0;
    cmd_d.msg_type   = req.msg_type;
    cmd_d.crc        = req.crc_flag;
    cmd_d.one_shot   = req.expects_no_answer;
    cmd_d.handle     = req.message_handle;
    push             = 1'b0;
    unique case (opcode_e'(req.opcode))
      OP_TICK:  begin cmd_d.kind = CMD_TICK;  push = 1'b1; end
      OP_FRAME: begin cmd_d.kind = CMD_FRAME; push = 1'b1; end
      OP_ENQ:   begin cmd_d.kind = CMD_ENQ;   push = 1'b1; end
      default:  begin cmd_d.kind = CMD_TICK;  push = 1'b0; end
    endcase
    if (req.expects_no_answer) begin
      cmd_d.tries = TriesW'(1);
      cmd_d.gap   = '0;
    end else begin
      cmd_d.gap = req.retry_gap_ms;
      if (req.repeat_count < RepCap) begin
        cmd_d.tries = req.repeat_count[TriesW-1:0] + TriesW'(1);
      end else begin
        cmd_d.tries = TriesMax;
      end
    end
    push = push && req.valid && req.ready;
  end

  assign pop = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  fifo_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("command queue count out of range");

  fifo_push_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("command queue lost a push");

  fifo_drop_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready && req.opcode == OP_NONE && !pop) |=> $stable(cnt_q))
    else $error("unused opcode reached the command queue");

endmodule

`default_nettype wire

>>> src/rrte_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rrte_back #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrte_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [15:0]       answer_timeout_i,
  input  logic [15:0]       cooldown_i,
  rrte_out_if.source        evt
);
  import rrte_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);

  typedef enum logic {ST_FETCH, ST_EXEC} state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q;
  req_t              mem [QUEUE_DEPTH];
  req_t              rd_q;
  logic              waiting_q, waiting_d;
  logic [TimeW-1:0]  cd_q, cd_d, rl_q, rl_d, ae_q, ae_d;
  logic [TypeW-1:0]  last_q, last_d;
  logic [PtrW-1:0]   head_q, head_d, head_nxt, tail;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SumW-1:0]   sum;
  result_t           res_q [2];
  logic [1:0]        out_cnt_q;
  result_t           r0, r1;
  logic [1:0]        nres;
  logic              fetch, exec, out_pop;
  logic              mem_we;
  logic [PtrW-1:0]   mem_wa;
  req_t              mem_wd;
  logic [TriesW-1:0] h_tries;
  logic [HandleW-1:0] h_handle;
  logic              do_pop, enq_ok;

  assign cmd_ready_o = (state_q == ST_FETCH);
  assign fetch       = cmd_ready_o && cmd_valid_i;
  assign exec        = (state_q == ST_EXEC) && (out_cnt_q == 2'd0);
  assign out_pop     = evt.valid && evt.ready;

  assign head_nxt = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
  assign sum      = SumW'(head_q) + SumW'(cnt_q);
  assign tail     = (sum >= DepthSum) ? PtrW'(sum - DepthSum) : PtrW'(sum);
  assign h_tries  = (cnt_q != '0) ? rd_q.tries  : '0;
  assign h_handle = (cnt_q != '0) ? rd_q.handle : '0;

  always_comb begin
    state_d   = state_q;
    waiting_d = waiting_q;
    cd_d      = cd_q;
    rl_d      = rl_q;
    ae_d      = ae_q;
    last_d    = last_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    r0        = '0;
    r1        = '0;
    nres      = 2'd0;
    mem_we    = 1'b0;
    mem_wa    = head_q;
    mem_wd    = rd_q;
    do_pop    = 1'b0;
    enq_ok    = 1'b0;
    if (fetch) state_d = ST_EXEC;
    if (exec) begin
      state_d = ST_FETCH;
      if (cmd_q.kind == CMD_TICK) begin
        if (cd_q != '0) cd_d = cd_q - TimeW'(1);
        if (rl_q != '0) rl_d = rl_q - TimeW'(1);
        if (waiting_q && ae_q != '1) ae_d = ae_q + TimeW'(1);
      end
      if (cmd_q.kind == CMD_ENQ) begin
        if (cnt_q >= DepthCnt) begin
          r0.kind       = EV_REJECT;
          r0.event_type = cmd_q.msg_type;
          r0.handle     = cmd_q.handle;
          nres          = 2'd1;
        end else begin
          enq_ok           = 1'b1;
          mem_we           = 1'b1;
          mem_wa           = tail;
          mem_wd.handle    = cmd_q.handle;
          mem_wd.msg_type  = cmd_q.msg_type;
          mem_wd.crc       = cmd_q.crc;
          mem_wd.one_shot  = cmd_q.one_shot;
          mem_wd.tries     = cmd_q.tries;
          mem_wd.gap       = cmd_q.gap;
          cnt_d            = cnt_q + CntW'(1);
        end
      end else if (!waiting_q) begin
        if (cmd_q.kind == CMD_FRAME) begin
          r0.kind       = EV_INCOMING;
          r0.event_type = cmd_q.msg_type;
          r0.crc        = cmd_q.crc;
          nres          = 2'd1;
        end
        if (cnt_q != '0 && cd_d == '0 && rl_d == '0) begin
          if (rd_q.tries != '0) begin
            r1.kind       = EV_SEND;
            r1.event_type = rd_q.msg_type;
            r1.crc        = rd_q.crc;
            r1.handle     = rd_q.handle;
            if (nres == 2'd0) r0 = r1;
            nres          = nres + 2'd1;
            last_d        = rd_q.msg_type;
            cd_d          = cooldown_i;
            mem_we        = 1'b1;
            mem_wa        = head_q;
            mem_wd.tries  = rd_q.tries - TriesW'(1);
            if (rd_q.one_shot) begin
              do_pop = 1'b1;
            end else begin
              waiting_d = 1'b1;
              ae_d      = '0;
              rl_d      = rd_q.gap;
            end
          end else begin
            do_pop = 1'b1;
          end
        end
      end else if (ae_d > answer_timeout_i) begin
        if (h_tries == '0) begin
          do_pop          = 1'b1;
          r0.kind         = EV_TIMEOUT;
          r0.event_type   = last_q;
          r0.request_type = last_q;
          r0.handle       = h_handle;
          nres            = 2'd1;
        end
        waiting_d = 1'b0;
      end else if (cmd_q.kind == CMD_FRAME) begin
        r0.kind         = EV_ANSWER;
        r0.event_type   = cmd_q.msg_type;
        r0.request_type = last_q;
        r0.crc          = cmd_q.crc;
        r0.handle       = h_handle;
        nres            = 2'd1;
        do_pop          = 1'b1;
        waiting_d       = 1'b0;
      end
      if (do_pop) begin
        rl_d = '0;
        if (cnt_q != '0) begin
          head_d = head_nxt;
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      r0.last = (nres == 2'd1);
      r1.last = 1'b1;
    end
  end

  // Request queue: one write port, registered head read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (fetch)  rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FETCH;
      cmd_q     <= '0;
      waiting_q <= 1'b0;
      cd_q      <= '0;
      rl_q      <= '0;
      ae_q      <= '0;
      last_q    <= '0;
      head_q    <= '0;
      cnt_q     <= '0;
      res_q[0]  <= '0;
      res_q[1]  <= '0;
      out_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      waiting_q <= waiting_d;
      cd_q      <= cd_d;
      rl_q      <= rl_d;
      ae_q      <= ae_d;
      last_q    <= last_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      if (fetch) cmd_q <= cmd_i;
      if (exec && nres != 2'd0) begin
        res_q[0]  <= r0;
        res_q[1]  <= r1;
        out_cnt_q <= nres;
      end else if (out_pop) begin
        res_q[0]  <= res_q[1];
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  assign evt.valid        = (out_cnt_q != 2'd0);
  assign evt.event_kind   = res_q[0].kind;
  assign evt.event_type   = res_q[0].event_type;
  assign evt.request_type = res_q[0].request_type;
  assign evt.event_crc    = res_q[0].crc;
  assign evt.event_handle = res_q[0].handle;
  assign evt.last_of_run  = res_q[0].last;

  queue_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt) else $error("request queue count above depth");

  wait_nonempty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> cnt_q != '0) else $error("waiting for an answer with no request");

  out_slots_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3) else $error("result slots overfilled");

  enq_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("enqueue did not grow the request queue");

endmodule

`default_nettype wire
